>>> src/binarize_projection_peak_locator_macros.svh
// assertion helpers used by the locator rtl
`ifndef BINARIZE_PROJECTION_PEAK_LOCATOR_MACROS_SVH
`define BINARIZE_PROJECTION_PEAK_LOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define BPL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/bpl_pkg.sv
package bpl_pkg;

	localparam int PIX_W    = 8;
	localparam int SUM_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 9;
	localparam int OUT_W    = 48;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN_COLUMNS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN_ON_LEFT = 3'd4;

	// register values after reset
	localparam logic [8:0] RST_REGION_WIDTH   = 9'd160;
	localparam logic [8:0] RST_REGION_HEIGHT  = 9'd40;
	localparam logic [7:0] RST_DARK_THRESHOLD = 8'd20;
	localparam logic [7:0] RST_MARGIN_COLUMNS = 8'd20;
	localparam logic       RST_MARGIN_ON_LEFT = 1'b0;

	localparam logic [SUM_W-1:0] DARK_VALUE = 16'd255;
	localparam logic [SUM_W-1:0] SUM_LIMIT  = 16'hFFFF;

	// requests from the pipeline to the column store
	typedef struct packed {
		logic rd;
		logic clear;
		logic wr;
	} col_req_t;

	// saturating add of one binarised pixel
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a, input logic dark);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (dark ? {1'b0, DARK_VALUE} : '0);
		return s[SUM_W] ? SUM_LIMIT : s[SUM_W-1:0];
	endfunction

endpackage

>>> src/bpl_col_store.sv
module bpl_col_store #(
	parameter int MAX_WIDTH = 256,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bpl_pkg::col_req_t       req,
	input  logic [AW-1:0]           rd_addr,
	input  logic [AW-1:0]           wr_addr,
	input  logic [bpl_pkg::SUM_W-1:0] wr_data,
	output logic [bpl_pkg::SUM_W-1:0] rd_data
);
	import bpl_pkg::*;

	logic [SUM_W-1:0]     mem [MAX_WIDTH];
	logic [MAX_WIDTH-1:0] valid_q;
	logic [SUM_W-1:0]     mem_rd_q;
	logic [SUM_W-1:0]     hit_data_q;
	logic                 hit_q;
	logic                 zero_q;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (req.rd) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	// read-side bypass: a write in the same cycle, or an entry not yet written this region
	always_ff @(posedge clk) begin
		if (req.rd) begin
			hit_q      <= req.wr && (wr_addr == rd_addr) && !req.clear;
			zero_q     <= req.clear || !valid_q[rd_addr];
			hit_data_q <= wr_data;
		end
	end

	// clearing wins over a late write from the previous region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clear) begin
			valid_q <= '0;
		end else if (req.wr) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = hit_q ? hit_data_q : (zero_q ? '0 : mem_rd_q);

endmodule

>>> src/binarize_projection_peak_locator.sv
// dark-pixel projection peak locator for one eye region
//
// s_* : pixel words of the region in row-major order, one grey value per word
// m_* : one result word after the last pixel of each region: first row and
//       first column with the largest positive dark sum, and both sums
// cfg_*: register writes (width, height, threshold, margin, margin side),
//        taken whenever cfg_valid is high; a pending write holds off pixels
//        for that cycle so it always lands between two pixel words
//
// one pixel per cycle sustained while no configuration write or full result
// buffer holds pixels off; each pixel reads its column sum in the accept cycle
// and writes it back in the next, so the column store's single read and write port sets the rate
// the result word is formed in stage 1 and then registered into the result buffer that drives m_*
// results sit in a two-word buffer; a region's last pixel is only taken while
// the buffer has room for its word, so a stalled receiver holds back just
// those pixels and one-pixel regions run at one pixel per cycle with a ready receiver
// reset restores the register defaults and starts a fresh region; column
// sums are invalidated at the first pixel of every region, no sweep needed
`include "binarize_projection_peak_locator_macros.svh"

module binarize_projection_peak_locator #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] pixel
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] row index, [15:8] column index, [31:16] row sum, [47:32] column sum
	output logic [bpl_pkg::OUT_W-1:0]     m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bpl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bpl_pkg::*;

	localparam int ColW = $clog2(MAX_WIDTH);
	localparam int RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WW   = ((ColW + 1 > 9) ? ColW + 1 : 9) + 1;
	localparam int HW   = (RowW + 1 > 9) ? RowW + 1 : 9;

	// configuration registers
	logic [8:0] region_width_q;
	logic [8:0] region_height_q;
	logic [7:0] dark_threshold_q;
	logic [7:0] margin_columns_q;
	logic       margin_on_left_q;

	// position counters, advanced at accept
	logic [ColW-1:0] col_cnt_q;
	logic [RowW-1:0] row_cnt_q;

	// stage 1: accepted pixel, column sum arrives from the store
	logic            valid_s1;
	logic            dark_s1;
	logic            counts_s1;
	logic            last_col_s1;
	logic            last_row_s1;
	logic [ColW-1:0] col_s1;
	logic [RowW-1:0] row_s1;

	// running sums and bests
	logic [SUM_W-1:0] row_sum_q;
	logic [SUM_W-1:0] best_row_sum_q;
	logic [RowW-1:0]  best_row_idx_q;
	logic [SUM_W-1:0] best_col_sum_q;
	logic [ColW-1:0]  best_col_idx_q;

	// result buffer: head drives m_*, second word waits behind it
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic             skid_valid_q;
	logic [OUT_W-1:0] skid_data_q;
	logic [OUT_W-1:0] result_word;
	logic             res_pop;
	logic             res_room;

	logic [WW-1:0] eff_w;
	logic [WW-1:0] w_ext;
	logic [HW-1:0] eff_h;
	logic [HW-1:0] h_ext;
	logic          last_col_now;
	logic          last_row_now;
	logic          counts_now;
	logic          final_now;
	logic          accept;
	logic          final_s1;

	col_req_t         col_req;
	logic [SUM_W-1:0] col_old;
	logic [SUM_W-1:0] col_new;
	logic [SUM_W-1:0] row_new;

	logic [SUM_W-1:0] best_row_sum_d;
	logic [RowW-1:0]  best_row_idx_d;
	logic [SUM_W-1:0] best_col_sum_d;
	logic [ColW-1:0]  best_col_idx_d;
	logic [RowW+7:0]  row_idx_ext;
	logic [ColW+7:0]  col_idx_ext;

	// ---------------------------------------------------------------
	// configuration
	// ---------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_width_q   <= RST_REGION_WIDTH;
			region_height_q  <= RST_REGION_HEIGHT;
			dark_threshold_q <= RST_DARK_THRESHOLD;
			margin_columns_q <= RST_MARGIN_COLUMNS;
			margin_on_left_q <= RST_MARGIN_ON_LEFT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_REGION_WIDTH:   region_width_q   <= cfg_data;
				REG_REGION_HEIGHT:  region_height_q  <= cfg_data;
				REG_DARK_THRESHOLD: dark_threshold_q <= cfg_data[7:0];
				REG_MARGIN_COLUMNS: margin_columns_q <= cfg_data[7:0];
				REG_MARGIN_ON_LEFT: margin_on_left_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective size: zero acts as one, oversize clamps to the maximum
	assign w_ext = WW'(region_width_q);
	assign h_ext = HW'(region_height_q);

	always_comb begin
		if (region_width_q == '0) begin
			eff_w = WW'(1);
		end else if (w_ext > WW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = w_ext;
		end
		if (region_height_q == '0) begin
			eff_h = HW'(1);
		end else if (h_ext > HW'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = h_ext;
		end
	end

	// ---------------------------------------------------------------
	// accept side
	// ---------------------------------------------------------------
	assign last_col_now = (WW'(col_cnt_q) + WW'(1)) >= eff_w;
	assign last_row_now = (HW'(row_cnt_q) + HW'(1)) >= eff_h;
	assign final_now    = last_col_now && last_row_now;
	assign final_s1     = valid_s1 && last_col_s1 && last_row_s1;

	// margin columns never contribute
	assign counts_now = margin_on_left_q ?
		(WW'(col_cnt_q) >= WW'(margin_columns_q)) :
		((WW'(col_cnt_q) + WW'(margin_columns_q)) < eff_w);

	// the last pixel of a region waits for room in the result buffer
	assign s_tready = !cfg_valid && (!final_now || res_room);
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (accept) begin
			if (!last_col_now) begin
				col_cnt_q <= col_cnt_q + ColW'(1);
			end else begin
				col_cnt_q <= '0;
				row_cnt_q <= last_row_now ? '0 : row_cnt_q + RowW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dark_s1     <= s_tdata < dark_threshold_q;
			counts_s1   <= counts_now;
			last_col_s1 <= last_col_now;
			last_row_s1 <= last_row_now;
			col_s1      <= col_cnt_q;
			row_s1      <= row_cnt_q;
		end
	end

	// ---------------------------------------------------------------
	// column store: read at accept, write back from stage 1
	// ---------------------------------------------------------------
	assign col_req.rd    = accept;
	assign col_req.clear = accept && (col_cnt_q == '0) && (row_cnt_q == '0);
	assign col_req.wr    = valid_s1 && counts_s1;

	bpl_col_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_col_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (col_req),
		.rd_addr (col_cnt_q),
		.wr_addr (col_s1),
		.wr_data (col_new),
		.rd_data (col_old)
	);

	// ---------------------------------------------------------------
	// stage 1: sums and peak tracking
	// ---------------------------------------------------------------
	assign col_new = sat_add(col_old, dark_s1);
	assign row_new = counts_s1 ? sat_add(row_sum_q, dark_s1) : row_sum_q;

	always_comb begin
		best_row_sum_d = best_row_sum_q;
		best_row_idx_d = best_row_idx_q;
		best_col_sum_d = best_col_sum_q;
		best_col_idx_d = best_col_idx_q;
		// column peaks are only judged on the last row, where sums are complete
		if (counts_s1 && last_row_s1 && (col_new > best_col_sum_q)) begin
			best_col_sum_d = col_new;
			best_col_idx_d = col_s1;
		end
		if (last_col_s1 && (row_new > best_row_sum_q)) begin
			best_row_sum_d = row_new;
			best_row_idx_d = row_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q      <= '0;
			best_row_sum_q <= '0;
			best_row_idx_q <= '0;
			best_col_sum_q <= '0;
			best_col_idx_q <= '0;
		end else if (valid_s1) begin
			row_sum_q <= last_col_s1 ? '0 : row_new;
			if (last_col_s1 && last_row_s1) begin
				best_row_sum_q <= '0;
				best_row_idx_q <= '0;
				best_col_sum_q <= '0;
				best_col_idx_q <= '0;
			end else begin
				best_row_sum_q <= best_row_sum_d;
				best_row_idx_q <= best_row_idx_d;
				best_col_sum_q <= best_col_sum_d;
				best_col_idx_q <= best_col_idx_d;
			end
		end
	end

	// ---------------------------------------------------------------
	// result buffer
	// ---------------------------------------------------------------
	assign row_idx_ext = {8'd0, best_row_idx_d};
	assign col_idx_ext = {8'd0, best_col_idx_d};
	assign result_word = {best_col_sum_d, best_row_sum_d, col_idx_ext[7:0], row_idx_ext[7:0]};

	assign res_pop = out_valid_q && m_tready;

	// room for the word of a last pixel accepted now, with an unknown receiver
	assign res_room = skid_valid_q ? (m_tready && !final_s1) :
		!(out_valid_q && final_s1 && !m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (res_pop) begin
			out_valid_q  <= skid_valid_q || final_s1;
			skid_valid_q <= skid_valid_q && final_s1;
		end else if (final_s1) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= out_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (res_pop) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				if (final_s1) begin
					skid_data_q <= result_word;
				end
			end else if (final_s1) begin
				out_data_q <= result_word;
			end
		end else if (final_s1) begin
			if (out_valid_q) begin
				skid_data_q <= result_word;
			end else begin
				out_data_q <= result_word;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	`BPL_ASSERT_NEXT(a_result_follows_final, clk, arst_n, final_s1, m_tvalid,
		"result word missing after the last pixel of a region")
	`BPL_ASSERT_NOW(a_no_result_overrun, clk, arst_n, final_s1, !skid_valid_q,
		"result buffer full when a new result arrives")
	`BPL_ASSERT_NOW(a_skid_behind_head, clk, arst_n, skid_valid_q, out_valid_q,
		"second result word held with an empty head")
	`BPL_ASSERT_NEXT(a_row_sum_cleared, clk, arst_n, valid_s1 && last_col_s1, row_sum_q == '0,
		"row sum not cleared at end of row")
	`BPL_ASSERT_NEXT(a_bests_cleared, clk, arst_n, final_s1,
		best_row_sum_q == '0 && best_col_sum_q == '0,
		"peak tracking not cleared after a result")

endmodule
